/* rtl/core/asgd_pkg.sv */
// Shared types, constants and table builder for the adaptive SGD update core.
// Used by asgd_div and adaptive_sgd_parameter_update_core; depends on nothing.
package asgd_pkg;

    localparam int MAX_PARAMS     = 1024;
    localparam int ADDR_W         = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;

    // Shared divider: 80-bit dividend, 64-bit divisor, one quotient bit a cycle.
    localparam int DIV_N_W   = 80;
    localparam int DIV_D_W   = 64;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [20:0] EXP_CLAMP = 21'd1310720;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_F_LOWER   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_F_UPPER   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_TIME = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GRAD = 1'b1;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

    typedef logic [30:0] exp_tab_t [EXP_SIZE];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = x_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(i/EXP_SIZE) in Q1.30, built from a repeated square root of two.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] r;
        logic [63:0] prod;
        r = 64'd1 << 31;
        for (int i = 0; i < EXP_TABLE_BITS; i++)
            r = isqrt64(r << 30);
        tab[0] = 31'd1 << 30;
        for (int i = 1; i < EXP_SIZE; i++)
        begin
            prod   = 64'(tab[i-1]) * r + (64'd1 << 29);
            tab[i] = prod[60:30];
        end
        return tab;
    endfunction

endpackage

/* rtl/core/asgd_div.sv */
// Shared restoring divider for the adaptive SGD core, one quotient bit per cycle.
// Depends on asgd_pkg for widths and the request and response structs.
module asgd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  asgd_pkg::div_req_t req,
    output asgd_pkg::div_rsp_t rsp
);
    import asgd_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_N_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/core/adaptive_sgd_parameter_update_core.sv */
// Top level of the adaptive SGD parameter update core: memories, sequencer, datapath.
// Depends on asgd_pkg and instantiates the shared divider asgd_div.
//
// The core keeps the parameters and the previous gradient in two on-chip memories of
// MAX_PARAMS words, each with a registered read. A load request (tuser low) writes one
// parameter in the cycle it is accepted. A gradient request (tuser high) is read,
// multiplied and written back in the steps accept, memory read, multiply, update and
// result; the last step waits while a result is held and not taken. The first gradient
// request of an iteration first works out the step size. That takes three passes
// through the shared divider plus the exponential, multiply and time steps. A step
// whose divisor is zero skips its divider pass. After reset the previous-gradient
// memory is cleared one entry a cycle, so no request is taken until the clearing is
// done, while configuration writes are taken throughout. The result register lets a
// new request be accepted while the previous result still waits for the downstream
// side.
module adaptive_sgd_parameter_update_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [asgd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [31:0]                         cfg_wdata,
    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: index[9:0], value[41:10], early_iteration[42], zero pad.
    input  logic [47:0]                         s_tdata,
    // s_tuser: opcode.
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: out_index[9:0], updated_param[41:10], zero pad.
    output logic [47:0]                         m_tdata,
    output logic                                m_tlast
);
    import asgd_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_DIV_X     = 13'b0000000000010,
        ST_EXP_MUL   = 13'b0000000000100,
        ST_EXP_ROM   = 13'b0000000001000,
        ST_EXP_SHIFT = 13'b0000000010000,
        ST_F_MUL     = 13'b0000000100000,
        ST_F_DEN     = 13'b0000001000000,
        ST_DIV_F     = 13'b0000010000000,
        ST_TIME      = 13'b0000100000000,
        ST_DIV_G     = 13'b0001000000000,
        ST_READ      = 13'b0010000000000,
        ST_CALC      = 13'b0100000000000,
        ST_UPD       = 13'b1000000000000
    } state_t;

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Memories.
    logic [31:0] param_mem [MAX_PARAMS];
    logic [31:0] pgrad_mem [MAX_PARAMS];

    // Configuration registers.
    logic [30:0]        gain_reg;
    logic [30:0]        offset_reg;
    logic signed [31:0] flo_reg;
    logic signed [31:0] fup_reg;
    logic [30:0]        scale_reg;

    // Control and iteration state.
    state_t             state_reg, state_next;
    logic               clr_active_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               open_reg;
    logic signed [63:0] dot_reg;
    logic signed [63:0] ndot_reg;
    logic signed [31:0] prev_time_reg;
    logic signed [31:0] step_reg;
    logic               m_tvalid_reg;

    // Current item.
    logic [9:0]         item_idx_reg;
    logic signed [31:0] item_val_reg;
    logic               item_early_reg;
    logic               item_last_reg;

    // Step-size datapath.
    logic signed [21:0] u_reg;
    logic signed [53:0] p_reg;
    logic signed [63:0] num_reg;
    logic [30:0]        mant_reg;
    logic signed [6:0]  shift_reg;
    logic [30:0]        e_reg;
    logic signed [63:0] fe_reg;
    logic signed [41:0] q_reg;

    // Per-item datapath.
    logic [31:0]        par_rd_reg;
    logic [31:0]        pg_rd_reg;
    logic signed [31:0] par_reg;
    logic signed [63:0] prod_step_reg;
    logic signed [63:0] prod_dot_reg;

    // Result register.
    logic [9:0]         out_idx_reg;
    logic [31:0]        out_param_reg;
    logic               out_last_reg;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               s_fire;
    logic               out_free;
    logic               in_ok;
    logic               item_ok;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  item_addr;
    logic [30:0]        omega;
    logic [20:0]        qm_c;
    logic [53:0]        p_bias;
    logic [21:0]        vb;
    logic [63:0]        mant_wide;
    logic [63:0]        e_wide;
    logic signed [63:0] den_c;
    logic [40:0]        qmag_c;
    logic signed [31:0] fq_c;
    logic signed [31:0] tsum_c;
    logic [30:0]        t_c;
    logic [31:0]        tden_c;
    logic signed [31:0] gamma_c;
    logic signed [63:0] delta_c;
    logic signed [31:0] np_c;
    logic signed [64:0] dsum_c;
    logic signed [63:0] dot_c;
    logic signed [32:0] fdiff_c;
    logic signed [64:0] num_full;

    asgd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_addr  = ADDR_W'(s_tdata[9:0]);
    assign item_addr = ADDR_W'(item_idx_reg);
    assign in_ok    = 32'(s_tdata[9:0]) < MAX_PARAMS;
    assign item_ok  = 32'(item_idx_reg) < MAX_PARAMS;

    always_comb
    begin
        omega = (scale_reg == '0) ? 31'd1 : scale_reg;

        // Clamp of -X/omega to the range the exponential covers.
        qm_c = (div_rsp.quotient > DIV_N_W'(EXP_CLAMP)) ? EXP_CLAMP
                                                        : div_rsp.quotient[20:0];

        // Floor of u*log2(e) in Q6.16, biased so that the integer part is positive.
        p_bias = 54'(p_reg) + (54'd1 << 51);
        vb     = p_bias[51:30];

        mant_wide = 64'(mant_reg);
        if (shift_reg[6])
            e_wide = mant_wide >> 6'(-shift_reg);
        else
            e_wide = mant_wide << shift_reg[3:0];

        fdiff_c  = 33'(fup_reg) - 33'(flo_reg);
        num_full = 65'(fdiff_c) * 65'(flo_reg);

        den_c = {{16{flo_reg[31]}}, flo_reg, 16'd0} - fe_reg;

        if (div_rsp.quotient >= (DIV_N_W'(1) << 40))
            qmag_c = 41'd1 << 40;
        else
            qmag_c = div_rsp.quotient[40:0];

        fq_c   = sat32(64'(flo_reg) + 64'(q_reg));
        tsum_c = sat32(64'(prev_time_reg) + 64'(fq_c));
        if (item_early_reg)
            t_c = offset_reg;
        else if (tsum_c[31])
            t_c = '0;
        else
            t_c = tsum_c[30:0];
        tden_c = 32'(t_c) + 32'(offset_reg);

        gamma_c = (div_rsp.quotient > DIV_N_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                             : div_rsp.quotient[31:0];

        // Step times gradient, truncated toward zero to Q16.16.
        delta_c = (prod_step_reg + (prod_step_reg[63] ? 64'sd65535 : 64'sd0)) >>> 16;
        np_c    = sat32(64'(par_reg) - delta_c);

        dsum_c = 65'(dot_reg) + 65'(prod_dot_reg);
        if (dsum_c[64] != dsum_c[63])
            dot_c = dsum_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            dot_c = dsum_c[63:0];
    end

    // Divider requests: the pass for -X/omega starts on acceptance, the other two
    // start from the state that has their operands ready.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_N_W'(mag64(ndot_reg));
        div_req.divisor  = DIV_D_W'(omega);
        case (state_reg)
            ST_IDLE:
            begin
                div_req.start = s_fire && (s_tuser == OP_GRAD) && !open_reg;
            end
            ST_F_DEN:
            begin
                div_req.start    = den_c != 64'sd0;
                div_req.dividend = {mag64(num_reg), 16'd0};
                div_req.divisor  = mag64(den_c);
            end
            ST_TIME:
            begin
                div_req.start    = tden_c != 32'd0;
                div_req.dividend = DIV_N_W'({gain_reg, 16'd0});
                div_req.divisor  = DIV_D_W'(tden_c);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_fire && (s_tuser == OP_GRAD))
                    state_next = open_reg ? ST_READ : ST_DIV_X;
            ST_DIV_X:
                if (div_rsp.done)
                    state_next = ST_EXP_MUL;
            ST_EXP_MUL:   state_next = ST_EXP_ROM;
            ST_EXP_ROM:   state_next = ST_EXP_SHIFT;
            ST_EXP_SHIFT: state_next = ST_F_MUL;
            ST_F_MUL:     state_next = ST_F_DEN;
            ST_F_DEN:
                state_next = (den_c == 64'sd0) ? ST_TIME : ST_DIV_F;
            ST_DIV_F:
                if (div_rsp.done)
                    state_next = ST_TIME;
            ST_TIME:
                state_next = (tden_c == 32'd0) ? ST_READ : ST_DIV_G;
            ST_DIV_G:
                if (div_rsp.done)
                    state_next = ST_READ;
            ST_READ:      state_next = ST_CALC;
            ST_CALC:      state_next = ST_UPD;
            ST_UPD:
                if (out_free)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and iteration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            gain_reg       <= 31'd65536;
            offset_reg     <= 31'd1310720;
            flo_reg        <= -32'sd32768;
            fup_reg        <= 32'sd131072;
            scale_reg      <= 31'd65536;
            prev_time_reg  <= '0;
            open_reg       <= 1'b0;
            dot_reg        <= '0;
            ndot_reg       <= '0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_PARAMS - 1))
                    clr_active_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_GAIN:      gain_reg   <= cfg_wdata[30:0];
                    CFG_OFFSET:    offset_reg <= cfg_wdata[30:0];
                    CFG_F_LOWER:   flo_reg    <= cfg_wdata;
                    CFG_F_UPPER:   fup_reg    <= cfg_wdata;
                    CFG_SCALE:     scale_reg  <= cfg_wdata[30:0];
                    CFG_INIT_TIME: prev_time_reg <= 32'(cfg_wdata[30:0]);
                    default:       ;
                endcase
            end

            // A new result takes the register in the cycle the old one leaves it.
            if ((state_reg == ST_UPD) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_TIME:
                begin
                    prev_time_reg <= 32'(t_c);
                    if (tden_c == 32'd0)
                    begin
                        step_reg <= (gain_reg == '0) ? 32'sd0 : 32'sh7FFFFFFF;
                        open_reg <= 1'b1;
                    end
                end
                ST_DIV_G:
                    if (div_rsp.done)
                    begin
                        step_reg <= gamma_c;
                        open_reg <= 1'b1;
                    end
                ST_UPD:
                    if (out_free)
                    begin
                        if (item_last_reg)
                        begin
                            ndot_reg <= (dot_c == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}}
                                                                 : -dot_c;
                            dot_reg  <= '0;
                            open_reg <= 1'b0;
                        end
                        else
                            dot_reg <= dot_c;
                    end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_idx_reg   <= s_tdata[9:0];
            item_val_reg   <= s_tdata[41:10];
            item_early_reg <= s_tdata[42];
            item_last_reg  <= s_tlast;
        end

        case (state_reg)
            ST_DIV_X:
                if (div_rsp.done)
                    u_reg <= (ndot_reg > 64'sd0) ? -22'($signed({1'b0, qm_c}))
                                                 : 22'($signed({1'b0, qm_c}));
            ST_EXP_MUL:
            begin
                p_reg   <= 54'(u_reg) * 54'($signed({1'b0, LOG2E_Q30}));
                num_reg <= num_full[63:0];
            end
            ST_EXP_ROM:
            begin
                mant_reg  <= EXP_TAB[vb[15 -: EXP_TABLE_BITS]];
                shift_reg <= 7'($signed({1'b0, vb[21:16]})) - 7'sd46;
            end
            ST_EXP_SHIFT:
                e_reg <= (e_wide > 64'h7FFFFFFF) ? 31'h7FFFFFFF : e_wide[30:0];
            ST_F_MUL:
                fe_reg <= 64'(fup_reg) * 64'($signed({1'b0, e_reg}));
            ST_F_DEN:
                if (den_c == 64'sd0)
                begin
                    if (num_reg == 64'sd0)
                        q_reg <= '0;
                    else
                        q_reg <= num_reg[63] ? -42'sd1099511627776 : 42'sd1099511627776;
                end
            ST_DIV_F:
                if (div_rsp.done)
                    q_reg <= (num_reg[63] != den_c[63]) ? -42'($signed({1'b0, qmag_c}))
                                                        : 42'($signed({1'b0, qmag_c}));
            ST_READ:
            begin
                par_rd_reg <= param_mem[item_addr];
                pg_rd_reg  <= pgrad_mem[item_addr];
            end
            ST_CALC:
            begin
                par_reg       <= item_ok ? par_rd_reg : 32'sd0;
                prod_step_reg <= 64'(step_reg) * 64'(item_val_reg);
                prod_dot_reg  <= 64'(item_val_reg) *
                                 64'($signed(item_ok ? pg_rd_reg : 32'd0));
            end
            ST_UPD:
                if (out_free)
                begin
                    out_idx_reg   <= item_idx_reg;
                    out_param_reg <= np_c;
                    out_last_reg  <= item_last_reg;
                end
            default: ;
        endcase
    end

    // Parameter memory: loads on acceptance, updates in the last step of an item.
    always_ff @(posedge clk)
    begin
        if (s_fire && (s_tuser == OP_LOAD) && in_ok)
            param_mem[in_addr] <= s_tdata[41:10];
        else if ((state_reg == ST_UPD) && out_free && item_ok)
            param_mem[item_addr] <= np_c;
    end

    // Previous-gradient memory: cleared after reset, then takes each new gradient.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            pgrad_mem[clr_addr_reg] <= '0;
        else if ((state_reg == ST_CALC) && item_ok)
            pgrad_mem[item_addr] <= item_val_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_param_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_sgd_parameter_update_core.
// Depends on asgd_pkg and the core; holds its own bit-exact predictor of the update.

class sgd_scoreboard;
    typedef struct {
        logic [9:0]  idx;
        logic [31:0] param;
        logic        last;
    } upd_t;

    upd_t           pending[$];
    int             errors;
    int             checked;

    // Configuration and state of the predictor.
    longint         gain, offset, flo, fhi, omega, init_time;
    logic [31:0]    params[1024];
    logic [31:0]    prev_grad[1024];
    longint         dot, neg_dot;
    int             prev_t, gamma;
    bit             open;
    logic [31:0]    exp_lut[1024];

    function new();
        longint unsigned r;
        errors = 0;
        checked = 0;
        gain = 65536; offset = 1310720; flo = -32768; fhi = 131072;
        omega = 65536; init_time = 0;
        foreach (params[i]) params[i] = '0;
        foreach (prev_grad[i]) prev_grad[i] = '0;
        dot = 0; neg_dot = 0; prev_t = 0; gamma = 0; open = 0;
        r = 64'd1 << 31;
        for (int i = 0; i < 10; i++)
            r = root(r << 30);
        exp_lut[0] = 32'd1 << 30;
        for (int i = 1; i < 1024; i++)
            exp_lut[i] = 32'((longint'(exp_lut[i-1]) * r + (64'd1 << 29)) >> 30);
    endfunction

    function longint unsigned root(longint unsigned x_in);
        longint unsigned x, res, b;
        x = x_in; res = 0; b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned mag(longint v);
        return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] d);
        case (addr)
            asgd_pkg::CFG_GAIN:      gain = d[30:0];
            asgd_pkg::CFG_OFFSET:    offset = d[30:0];
            asgd_pkg::CFG_F_LOWER:   flo = longint'(signed'(d));
            asgd_pkg::CFG_F_UPPER:   fhi = longint'(signed'(d));
            asgd_pkg::CFG_SCALE:     omega = d[30:0];
            asgd_pkg::CFG_INIT_TIME:
            begin
                init_time = d[30:0];
                prev_t = int'(init_time);
            end
            default: ;
        endcase
    endfunction

    function longint exp_fix(longint u_in);
        longint u, p, n, s;
        longint unsigned vb, m, e;
        u = u_in;
        if (u > 1310720) u = 1310720;
        if (u < -1310720) u = -1310720;
        p = u * 64'sd1549082005;
        vb = longint'(p + (64'sd32 << 46)) >> 30;
        n = longint'(vb >> 16) - 32;
        m = exp_lut[(vb & 64'hFFFF) >> 6];
        s = n - 14;
        e = s >= 0 ? m << s : m >> (-s);
        if (e > 64'd2147483647) e = 64'd2147483647;
        return e;
    endfunction

    // floor(num * 2^16 / den), capped; restoring steps as the datapath does them.
    function longint unsigned frac_div(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        q = num / den; r = num % den;
        if (q >= (64'd1 << 24)) return 64'd1 << 40;
        for (int k = 0; k < 16; k++)
        begin
            q = q << 1;
            if (r >= den - r)
            begin
                r = r - (den - r);
                q = q | 1;
            end
            else
                r = r + r;
        end
        return q;
    endfunction

    function void work_out_step(bit early);
        longint om, u, e, num, den, q, t, g, tden;
        longint unsigned qm, qmag;
        bit neg;
        om = omega == 0 ? 1 : omega;
        qm = mag(neg_dot) / longint'(om);
        if (qm > 1310720) qm = 1310720;
        u = neg_dot > 0 ? -longint'(qm) : longint'(qm);
        e = exp_fix(u);
        num = (fhi - flo) * flo;
        den = flo * 65536 - fhi * e;
        if (den == 0)
        begin
            qmag = num == 0 ? 0 : (64'd1 << 40);
            neg = num < 0;
        end
        else
        begin
            qmag = frac_div(mag(num), mag(den));
            neg = (num < 0) != (den < 0);
        end
        q = neg ? -longint'(qmag) : longint'(qmag);
        if (early)
            t = offset;
        else
        begin
            t = clip32(longint'(prev_t) + clip32(flo + q));
            if (t < 0) t = 0;
        end
        prev_t = int'(t);
        tden = t + offset;
        if (tden == 0)
            g = gain == 0 ? 0 : 64'sd2147483647;
        else
        begin
            g = (gain * 65536) / tden;
            if (g > 64'sd2147483647) g = 64'sd2147483647;
        end
        gamma = int'(g);
        open = 1;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(bit op, logic [9:0] idx, logic [31:0] val, bit early, bit last);
        longint v, par, pg, delta, prod, sum;
        upd_t u;
        if (op == asgd_pkg::OP_LOAD)
        begin
            params[idx] = val;
            return;
        end
        if (!open) work_out_step(early);
        v = longint'(signed'(val));
        par = longint'(signed'(params[idx]));
        pg = longint'(signed'(prev_grad[idx]));
        delta = (longint'(gamma) * v) / 65536;
        u.param = 32'(clip32(par - delta));
        prod = v * pg;
        sum = dot + prod;
        if (prod > 0 && dot > 0 && sum < 0) sum = 64'h7FFFFFFFFFFFFFFF;
        else if (prod < 0 && dot < 0 && sum >= 0) sum = 64'h8000000000000000;
        dot = sum;
        params[idx] = u.param;
        prev_grad[idx] = val;
        if (last)
        begin
            neg_dot = dot == 64'h8000000000000000 ? 64'h7FFFFFFFFFFFFFFF : -dot;
            dot = 0;
            open = 0;
        end
        u.idx = idx;
        u.last = last;
        pending.push_back(u);
    endfunction

    function void check_update(logic [47:0] data, logic last);
        upd_t exp_u;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result idx=%0d param=%h", $time, data[9:0], data[41:10]);
            errors++;
            return;
        end
        exp_u = pending.pop_front();
        checked++;
        if (data[9:0] !== exp_u.idx)
        begin
            $display("%0t: index expected %0d actual %0d", $time, exp_u.idx, data[9:0]);
            errors++;
        end
        if (data[41:10] !== exp_u.param)
        begin
            $display("%0t: param expected %h actual %h", $time, exp_u.param, data[41:10]);
            errors++;
        end
        if (data[47:42] !== 6'd0)
        begin
            $display("%0t: pad expected 0 actual %h", $time, data[47:42]);
            errors++;
        end
        if (last !== exp_u.last)
        begin
            $display("%0t: last expected %b actual %b", $time, exp_u.last, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import asgd_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata from bit 0: index[9:0], value[41:10], early_iteration[42], zero pad.
    logic [47:0]           s_tdata;
    // s_tuser: opcode.
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata from bit 0: out_index[9:0], updated_param[41:10], zero pad.
    logic [47:0]           m_tdata;
    logic                  m_tlast;

    sgd_scoreboard board;
    int            idle_cycles;
    int            sent;
    int            iterations;
    bit            calm;        // when set, neither side idles
    bit            loaded[1024];
    logic [9:0]    loaded_list[$];

    adaptive_sgd_parameter_update_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The result side stalls with a chance of about 28 percent each time unless the run is calm.
    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);

    // Results are checked at the edge that accepts them.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_update(m_tdata, m_tlast);

    // Watchdog: counts cycles in which neither side accepts anything.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drives one request and holds it until the core takes it, idling before it at random.
    // Valid stays high after acceptance; the next request or an idle cycle replaces it.
    task automatic send_request(bit op, logic [9:0] idx, logic [31:0] val, bit early, bit last);
        while (!calm && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {5'd0, early, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(op, idx, val, early, last);
        if (op == OP_GRAD) sent++;
    endtask

    task automatic load_param(logic [9:0] idx, logic [31:0] val);
        send_request(OP_LOAD, idx, val, 1'b0, 1'b0);
        if (!loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= d;
        @(posedge clk);
        board.write_reg(addr, d);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            default: return 32'($signed($urandom_range(131071)) - 65536);
        endcase
    endfunction

    // One iteration over loaded indices in list order, starting at a random entry and wrapping.
    task automatic run_iteration(int len, bit early);
        int base;
        base = $urandom_range(loaded_list.size() - 1);
        for (int k = 0; k < len; k++)
            send_request(OP_GRAD, loaded_list[(base + k) % loaded_list.size()],
                         rand_grad(), early, k == len - 1);
        iterations++;
    endtask

    function automatic logic [31:0] rand_cfg(logic [2:0] addr);
        case (addr)
            CFG_F_LOWER: return $urandom_range(1) ? 32'hFFFF8000 :
                                ({1'b1, 31'($urandom)} | 32'h8000_0000);
            CFG_F_UPPER: return $urandom_range(1) ? 32'(131072 + $urandom_range(65536)) : $urandom;
            CFG_SCALE:   return $urandom_range(1) ? 32'd65536 : {1'b0, 31'($urandom)};
            default:     return $urandom_range(1) ? 32'($urandom_range(1 << 21)) : {1'b0, 31'($urandom)};
        endcase
    endfunction

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_LOAD; s_tlast = 1'b0;
        m_tready = 1'b0;
        idle_cycles = 0; sent = 0; iterations = 0; calm = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, loads, an out-of-order repeat index, early and late steps.
        load_param(10'd0, 32'h7FFFFFFF);
        load_param(10'd1023, 32'h80000000);
        load_param(10'd5, 32'h00010000);
        send_request(OP_GRAD, 10'd0, 32'h80000000, 1'b1, 1'b0);
        send_request(OP_GRAD, 10'd5, 32'h7FFFFFFF, 1'b1, 1'b0);
        load_param(10'd7, 32'hFFFF0000);         // load in the middle of an iteration
        send_request(OP_GRAD, 10'd1023, 32'h7FFFFFFF, 1'b0, 1'b1);
        send_request(OP_GRAD, 10'd5, 32'h00020000, 1'b0, 1'b0);
        send_request(OP_GRAD, 10'd5, 32'hFFFE0000, 1'b0, 1'b0);   // repeated index
        send_request(OP_GRAD, 10'd7, 32'h0, 1'b0, 1'b1);
        send_request(OP_GRAD, 10'd1023, 32'h80000000, 1'b0, 1'b1);  // one-item iteration
        drain();

        // Register extremes: zero omega, singular denominator, zero t + A, zero gain.
        write_reg(CFG_SCALE, 32'd0);
        write_reg(CFG_F_UPPER, 32'hFFFF8000);      // fmax = fmin gives num = 0
        write_reg(CFG_OFFSET, 32'd0);
        write_reg(CFG_INIT_TIME, 32'd0);
        send_request(OP_GRAD, 10'd0, 32'h00010000, 1'b0, 1'b1);
        drain();
        write_reg(CFG_GAIN, 32'd0);
        send_request(OP_GRAD, 10'd5, 32'h00010000, 1'b1, 1'b1);
        drain();
        write_reg(CFG_GAIN, 32'h7FFFFFFF);
        write_reg(CFG_OFFSET, 32'h7FFFFFFF);
        write_reg(CFG_F_LOWER, 32'h80000000);
        write_reg(CFG_F_UPPER, 32'h7FFFFFFF);
        write_reg(CFG_SCALE, 32'h7FFFFFFF);
        write_reg(CFG_INIT_TIME, 32'h7FFFFFFF);
        send_request(OP_GRAD, 10'd0, 32'hFFFFFFFF, 1'b0, 1'b0);
        send_request(OP_GRAD, 10'd1023, 32'h00000001, 1'b0, 1'b1);
        drain();
        write_reg(CFG_F_LOWER, 32'hFFFFFFFF);
        write_reg(CFG_F_UPPER, 32'h80000000);
        write_reg(CFG_SCALE, 32'd1);
        send_request(OP_GRAD, 10'd5, 32'h00400000, 1'b0, 1'b1);
        drain();

        // Random phases: new settings, more parameters, then iterations of varied length.
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
                for (int a = 0; a < 6; a++)
                    write_reg(3'(a), 32'(a == 0 ? 65536 : a == 1 ? 1310720 :
                              a == 2 ? 32'hFFFF8000 : a == 3 ? 131072 : a == 4 ? 65536 : 0));
            else
                for (int a = 0; a < 6; a++)
                    if ($urandom_range(1)) write_reg(3'(a), rand_cfg(3'(a)));
            calm = (ph == 4);
            repeat (20) load_param(10'($urandom), $urandom);
            while (sent < 150 * (ph + 1))
            begin
                if ($urandom_range(9) == 0)
                    load_param(10'($urandom), $urandom);
                else if ($urandom_range(19) == 0)
                    send_request(OP_GRAD, loaded_list[$urandom_range(loaded_list.size() - 1)],
                                 rand_grad(), $urandom_range(1), $urandom_range(1));
                else
                    run_iteration($urandom_range(40, 1), $urandom_range(3) == 0);
            end
            // Close any open iteration so the phase ends idle.
            send_request(OP_GRAD, loaded_list[0], rand_grad(), 1'b0, 1'b1);
            drain();
        end

        calm = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d gradient requests in %0d iterations, %0d results checked,",
                 sent, iterations, board.checked);
        $display("with register extremes, load interleaving and random back-pressure.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
